/* design/integer_to_ascii_formatter_macros.svh */
// Assertion macros for the integer to ASCII formatter.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ITAF_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ITAF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ITAF_ASSERT_IMPL(lbl, pre, post)
`define ITAF_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

/* design/itaf_pkg.sv */
// Types, character codes and helper functions for the integer to ASCII formatter.
// Self-contained; imported by the formatter top level.
package itaf_pkg;

  localparam int MaxChars = 21;
  localparam int CntW     = 5;
  localparam int BcdW     = 20;

  typedef enum logic [1:0] {
    ModeHex = 2'd0,
    ModeDec = 2'd1,
    ModeBin = 2'd2,
    ModeRaw = 2'd3
  } display_mode_t;

  typedef enum logic [1:0] {
    RegDisplayMode = 2'd0,
    RegWordMode    = 2'd1,
    RegBitCount    = 2'd2,
    RegQuiet       = 2'd3
  } cfg_reg_t;

  typedef logic [MaxChars-1:0][7:0] char_buf_t;
  typedef logic [CntW-1:0]          char_cnt_t;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChAlpha = 8'h37; // 'A' less ten

  localparam logic [4:0] BitCountReset = 5'd8;

  // Upper-case hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ChZero + {4'h0, d};
    end else begin
      c = ChAlpha + {4'h0, d};
    end
    return c;
  endfunction

  // One shift-and-add-three step of the binary to BCD conversion.
  function automatic logic [BcdW-1:0] dabble_step(input logic [BcdW-1:0] bcd,
                                                   input logic          b);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int k = 0; k < BcdW / 4; k++) begin
      if (adj[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
      end
    end
    return {adj[BcdW-2:0], b};
  endfunction

  function automatic logic [7:0] bit_char(input logic b);
    return b ? ChOne : ChZero;
  endfunction

endpackage

/* design/integer_to_ascii_formatter.sv */
// Integer to ASCII formatter top level: masking, BCD conversion, run build and serialiser.
// Depends on itaf_pkg and integer_to_ascii_formatter_macros.svh.
`include "integer_to_ascii_formatter_macros.svh"

// Each accepted 16-bit value is masked to the configured bit count and sent out as a run
// of 8-bit characters, one per beat, with tlast on the final character of the run: hex
// ("0x" and two or four digits), decimal (leading zeros suppressed, "0" for zero), binary
// ("0b", eight bits per byte, a space and "0b" between bytes in word mode) or raw bytes.
// A value passes through five register stages (mask, two halves of the BCD conversion,
// run build, serialiser) before its first character is offered on the output.
// While out_tready is high the serialiser emits one character per cycle. A run has 1 to 5
// characters in decimal, 4 or 6 in hex, 10 or 21 in binary and 1 or 2 raw. Runs follow
// each other without gaps while values keep arriving. With quiet set, values are accepted
// and produce no beats. Configuration writes are taken in every cycle and must be made
// only while no run is in flight.
module integer_to_ascii_formatter
  import itaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] character
  output logic        out_tlast,  // last
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [4:0]  cfg_data
);

  // Configuration registers
  display_mode_t mode_r, mode_nxt;
  logic          word_r, word_nxt;
  logic [4:0]    bit_count_r, bit_count_nxt;
  logic          quiet_r, quiet_nxt;

  // Pipeline registers
  logic          s1_valid_r, s1_valid_nxt;
  logic [15:0]   s1_value_r, s1_value_nxt;
  display_mode_t s1_mode_r;
  logic          s1_word_r;

  logic          s2_valid_r, s2_valid_nxt;
  logic [15:0]   s2_value_r;
  logic [11:0]   s2_bcd_r, s2_bcd_nxt;
  display_mode_t s2_mode_r;
  logic          s2_word_r;

  logic          s3_valid_r, s3_valid_nxt;
  logic [15:0]   s3_value_r;
  logic [BcdW-1:0] s3_bcd_r, s3_bcd_nxt;
  display_mode_t s3_mode_r;
  logic          s3_word_r;

  logic          s4_valid_r, s4_valid_nxt;
  char_buf_t     s4_buf_r, s4_buf_nxt;
  char_cnt_t     s4_cnt_r, s4_cnt_nxt;

  logic          em_valid_r, em_valid_nxt;
  char_buf_t     em_buf_r, em_buf_nxt;
  char_cnt_t     em_cnt_r, em_cnt_nxt;

  logic s1_en, s2_en, s3_en, s4_en, em_free;
  logic in_acc, cfg_acc;
  logic [15:0] mask;
  logic [BcdW-1:0] bcd_hi, bcd_lo, bcd_sh;
  logic [2:0] ndig;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  always_comb begin
    mode_nxt      = mode_r;
    word_nxt      = word_r;
    bit_count_nxt = bit_count_r;
    quiet_nxt     = quiet_r;
    if (cfg_acc) begin
      case (cfg_reg_t'(cfg_addr))
        RegDisplayMode: mode_nxt      = display_mode_t'(cfg_data[1:0]);
        RegWordMode:    word_nxt      = cfg_data[0];
        RegBitCount:    bit_count_nxt = cfg_data;
        RegQuiet:       quiet_nxt     = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stall chain: a stage moves on when it is empty or its successor is moving.
  assign em_free   = !em_valid_r || (out_tready && (em_cnt_r == char_cnt_t'(1)));
  assign s4_en     = !s4_valid_r || em_free;
  assign s3_en     = !s3_valid_r || s4_en;
  assign s2_en     = !s2_valid_r || s3_en;
  assign s1_en     = !s1_valid_r || s2_en;
  assign in_tready = s1_en;
  assign in_acc    = in_tvalid & in_tready;

  // Stage 1: masking. Quiet values are taken and dropped here.
  always_comb begin
    if (bit_count_r >= 5'd16) begin
      mask = 16'hFFFF;
    end else begin
      mask = (16'h0001 << bit_count_r[3:0]) - 16'h0001;
    end
    s1_value_nxt = in_tdata & mask;
    if (!word_r) begin
      s1_value_nxt[15:8] = 8'h00;
    end
    s1_valid_nxt = in_acc && !quiet_r;
  end

  // Stage 2: BCD conversion of the high byte.
  always_comb begin
    bcd_hi = '0;
    for (int i = 15; i >= 8; i--) begin
      bcd_hi = dabble_step(bcd_hi, s1_value_r[i]);
    end
    s2_bcd_nxt   = bcd_hi[11:0];
    s2_valid_nxt = s1_valid_r;
  end

  // Stage 3: BCD conversion of the low byte.
  always_comb begin
    bcd_lo = {8'h00, s2_bcd_r};
    for (int i = 7; i >= 0; i--) begin
      bcd_lo = dabble_step(bcd_lo, s2_value_r[i]);
    end
    s3_bcd_nxt   = bcd_lo;
    s3_valid_nxt = s2_valid_r;
  end

  // Stage 4: lay out the run, first character in the lowest slot.
  always_comb begin
    s4_buf_nxt   = '0;
    s4_cnt_nxt   = '0;
    s4_valid_nxt = s3_valid_r;
    if (s3_bcd_r[19:16] != 4'd0) begin
      ndig = 3'd5;
    end else if (s3_bcd_r[15:12] != 4'd0) begin
      ndig = 3'd4;
    end else if (s3_bcd_r[11:8] != 4'd0) begin
      ndig = 3'd3;
    end else if (s3_bcd_r[7:4] != 4'd0) begin
      ndig = 3'd2;
    end else begin
      ndig = 3'd1;
    end
    // Bring the most significant digit to the top of the word.
    case (ndig)
      3'd5:    bcd_sh = s3_bcd_r;
      3'd4:    bcd_sh = {s3_bcd_r[15:0], 4'h0};
      3'd3:    bcd_sh = {s3_bcd_r[11:0], 8'h00};
      3'd2:    bcd_sh = {s3_bcd_r[7:0], 12'h000};
      default: bcd_sh = {s3_bcd_r[3:0], 16'h0000};
    endcase
    case (s3_mode_r)
      ModeHex: begin
        s4_buf_nxt[0] = ChZero;
        s4_buf_nxt[1] = ChX;
        if (s3_word_r) begin
          s4_buf_nxt[2] = hex_char(s3_value_r[15:12]);
          s4_buf_nxt[3] = hex_char(s3_value_r[11:8]);
          s4_buf_nxt[4] = hex_char(s3_value_r[7:4]);
          s4_buf_nxt[5] = hex_char(s3_value_r[3:0]);
          s4_cnt_nxt    = char_cnt_t'(6);
        end else begin
          s4_buf_nxt[2] = hex_char(s3_value_r[7:4]);
          s4_buf_nxt[3] = hex_char(s3_value_r[3:0]);
          s4_cnt_nxt    = char_cnt_t'(4);
        end
      end
      ModeDec: begin
        for (int i = 0; i < 5; i++) begin
          if (3'(i) < ndig) begin
            s4_buf_nxt[i] = {4'h3, bcd_sh[BcdW-1-4*i -: 4]};
          end
        end
        s4_cnt_nxt = char_cnt_t'(ndig);
      end
      ModeBin: begin
        s4_buf_nxt[0] = ChZero;
        s4_buf_nxt[1] = ChB;
        if (s3_word_r) begin
          for (int i = 0; i < 8; i++) begin
            s4_buf_nxt[2+i]  = bit_char(s3_value_r[15-i]);
            s4_buf_nxt[13+i] = bit_char(s3_value_r[7-i]);
          end
          s4_buf_nxt[10] = ChSpace;
          s4_buf_nxt[11] = ChZero;
          s4_buf_nxt[12] = ChB;
          s4_cnt_nxt     = char_cnt_t'(MaxChars);
        end else begin
          for (int i = 0; i < 8; i++) begin
            s4_buf_nxt[2+i] = bit_char(s3_value_r[7-i]);
          end
          s4_cnt_nxt = char_cnt_t'(10);
        end
      end
      default: begin
        if (s3_word_r) begin
          s4_buf_nxt[0] = s3_value_r[15:8];
          s4_buf_nxt[1] = s3_value_r[7:0];
          s4_cnt_nxt    = char_cnt_t'(2);
        end else begin
          s4_buf_nxt[0] = s3_value_r[7:0];
          s4_cnt_nxt    = char_cnt_t'(1);
        end
      end
    endcase
  end

  // Serialiser: one character per beat, the run shifts down as beats are taken.
  always_comb begin
    em_valid_nxt = em_valid_r;
    em_buf_nxt   = em_buf_r;
    em_cnt_nxt   = em_cnt_r;
    if (em_free && s4_valid_r) begin
      em_valid_nxt = 1'b1;
      em_buf_nxt   = s4_buf_r;
      em_cnt_nxt   = s4_cnt_r;
    end else if (em_valid_r && out_tready) begin
      em_valid_nxt = (em_cnt_r != char_cnt_t'(1));
      em_buf_nxt   = {8'h00, em_buf_r[MaxChars-1:1]};
      em_cnt_nxt   = em_cnt_r - char_cnt_t'(1);
    end
  end

  assign out_tvalid = em_valid_r;
  assign out_tdata  = em_buf_r[0];
  assign out_tlast  = (em_cnt_r == char_cnt_t'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ModeHex;
      word_r      <= 1'b0;
      bit_count_r <= BitCountReset;
      quiet_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      em_valid_r  <= 1'b0;
      em_cnt_r    <= '0;
    end else begin
      mode_r      <= mode_nxt;
      word_r      <= word_nxt;
      bit_count_r <= bit_count_nxt;
      quiet_r     <= quiet_nxt;
      em_valid_r  <= em_valid_nxt;
      em_cnt_r    <= em_cnt_nxt;
      if (s1_en) begin
        s1_valid_r <= s1_valid_nxt;
      end
      if (s2_en) begin
        s2_valid_r <= s2_valid_nxt;
      end
      if (s3_en) begin
        s3_valid_r <= s3_valid_nxt;
      end
      if (s4_en) begin
        s4_valid_r <= s4_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    em_buf_r <= em_buf_nxt;
    if (s1_en) begin
      s1_value_r <= s1_value_nxt;
      s1_mode_r  <= mode_r;
      s1_word_r  <= word_r;
    end
    if (s2_en) begin
      s2_value_r <= s1_value_r;
      s2_bcd_r   <= s2_bcd_nxt;
      s2_mode_r  <= s1_mode_r;
      s2_word_r  <= s1_word_r;
    end
    if (s3_en) begin
      s3_value_r <= s2_value_r;
      s3_bcd_r   <= s3_bcd_nxt;
      s3_mode_r  <= s2_mode_r;
      s3_word_r  <= s2_word_r;
    end
    if (s4_en) begin
      s4_buf_r <= s4_buf_nxt;
      s4_cnt_r <= s4_cnt_nxt;
    end
  end

  // A run in the serialiser always has characters left to send.
  `ITAF_ASSERT_IMPL(a_em_cnt_nonzero, em_valid_r, em_cnt_r != char_cnt_t'(0))
  // Every built run holds between one and the maximum number of characters.
  `ITAF_ASSERT_IMPL(a_s4_cnt_range, s4_valid_r,
    (s4_cnt_r != char_cnt_t'(0)) && (s4_cnt_r <= char_cnt_t'(MaxChars)))
  // Within a run the next character follows in the very next cycle.
  `ITAF_ASSERT_NEXT(a_run_unbroken, out_tvalid && out_tready && !out_tlast, out_tvalid)
  // The BCD conversion yields decimal digits only.
  `ITAF_ASSERT_IMPL(a_bcd_digits, s3_valid_r,
    (s3_bcd_r[3:0] <= 4'd9) && (s3_bcd_r[7:4] <= 4'd9) && (s3_bcd_r[11:8] <= 4'd9) &&
    (s3_bcd_r[15:12] <= 4'd9) && (s3_bcd_r[19:16] <= 4'd6))
  // An accepted value that is not silenced enters the pipeline.
  `ITAF_ASSERT_NEXT(a_enter, in_tvalid && in_tready && !quiet_r, s1_valid_r)

endmodule
